>>> rtl/bfscd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfscd_pkg: shared types and constants for the BFS cycle detector
// Sizes of the edge store and walk queue, field codes, and the
// command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package bfscd_pkg;

  localparam int MAX_VERTICES = 256;
  localparam int MAX_EDGES    = 1024;
  // each edge enqueues at most once per walk, plus the start vertex
  localparam int QUEUE_DEPTH  = 2 * MAX_EDGES;

  localparam int VID_W  = 8;                          // vertex id field
  localparam int CFG_W  = 9;                          // vertex_count register
  localparam int EA_W   = $clog2(MAX_EDGES);          // edge store index
  localparam int ECNT_W = $clog2(MAX_EDGES + 1);      // edge count
  localparam int QA_W   = $clog2(QUEUE_DEPTH);        // queue index
  localparam int QC_W   = $clog2(QUEUE_DEPTH + 1);    // queue head / tail
  localparam int ERR_W  = 2;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam int RIDX_W = ADDR_W - 2;

  // input mode codes
  localparam logic MODE_ADD    = 1'b0;
  localparam logic MODE_FINISH = 1'b1;

  // load_error codes
  localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd1;
  localparam logic [ERR_W-1:0] ERR_RANGE    = 2'd2;

  // register indexes
  localparam logic [RIDX_W-1:0] REG_VERTEX_COUNT = 1'b0;

  typedef struct packed {
    logic [VID_W-1:0] a;
    logic [VID_W-1:0] b;
  } bfscd_edge_t;

  typedef struct packed {
    logic edge_add;    // store an edge from the input transfer
    logic walk_init;   // start of evaluation: outer vertex counter to zero
    logic vtx_next;    // advance outer vertex counter
    logic walk_start;  // queue := {current outer vertex}
    logic deq;         // read queue head
    logic mark;        // mark dequeued vertex, start edge scan
    logic scan;        // edge scan running
    logic post;        // load result register, clear graph state
    logic found;       // cycle flag for post
  } bfscd_cmd_t;

  typedef struct packed {
    logic vtx_end;     // outer counter reached vertex_count
    logic vtx_seen;    // outer vertex already visited
    logic q_empty;
    logic deq_seen;    // dequeued vertex already visited
    logic scan_done;
    logic out_free;    // result register can take a new result
  } bfscd_sts_t;

endpackage
`default_nettype wire

>>> rtl/bfscd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfscd_ctrl: sequencer for the BFS cycle detector
// Accepts edge and finish transfers, then steps the datapath through the
// outer vertex loop, queue dequeues and edge scans.
// ----------------------------------------------------------------------------
module bfscd_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_mode,
  input  wire bfscd_pkg::bfscd_sts_t sts,
  output bfscd_pkg::bfscd_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_LOAD,
    S_OUTER,
    S_DEQ,
    S_CHECK,
    S_SCAN,
    S_RESULT
  } state_t;

  state_t state_r, state_nxt;
  logic   found_r, found_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    found_nxt = found_r;
    unique case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          if (in_mode == bfscd_pkg::MODE_FINISH) begin
            cmd.walk_init = 1'b1;
            found_nxt     = 1'b0;
            state_nxt     = S_OUTER;
          end else begin
            cmd.edge_add = 1'b1;
          end
        end
      end
      S_OUTER: begin
        if (sts.vtx_end) begin
          state_nxt = S_RESULT;
        end else if (sts.vtx_seen) begin
          cmd.vtx_next = 1'b1;
        end else begin
          cmd.walk_start = 1'b1;
          state_nxt      = S_DEQ;
        end
      end
      S_DEQ: begin
        if (sts.q_empty) begin
          cmd.vtx_next = 1'b1;
          state_nxt    = S_OUTER;
        end else begin
          cmd.deq   = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.deq_seen) begin
          found_nxt = 1'b1;
          state_nxt = S_RESULT;
        end else begin
          cmd.mark  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_DEQ;
        end
      end
      S_RESULT: begin
        cmd.found = found_r;
        if (sts.out_free) begin
          cmd.post  = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      found_r <= found_nxt;
    end
  end

  assign in_stall = (state_r != S_LOAD);

endmodule
`default_nettype wire

>>> rtl/bfscd_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfscd_datapath: edge store, walk queue, visited marks and result register
// Executes controller commands; the edge scan is a two-stage pipe
// (memory read, then neighbor test and enqueue).
// ----------------------------------------------------------------------------
module bfscd_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire bfscd_pkg::bfscd_cmd_t               cmd,
  output bfscd_pkg::bfscd_sts_t                    sts,
  input  wire logic [bfscd_pkg::CFG_W-1:0]         vertex_count,
  input  wire logic [bfscd_pkg::VID_W-1:0]         in_end_a,
  input  wire logic [bfscd_pkg::VID_W-1:0]         in_end_b,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic                                     out_cycle_found,
  output logic [bfscd_pkg::ERR_W-1:0]              out_load_error
);

  // memories
  bfscd_pkg::bfscd_edge_t           edge_mem [bfscd_pkg::MAX_EDGES];
  logic [bfscd_pkg::VID_W-1:0]      q_mem    [bfscd_pkg::QUEUE_DEPTH];

  bfscd_pkg::bfscd_edge_t           edge_q_r;
  logic [bfscd_pkg::VID_W-1:0]      q_rd_r;

  // control state
  logic [bfscd_pkg::ECNT_W-1:0]       edge_total_r, edge_total_nxt;
  logic [bfscd_pkg::ERR_W-1:0]        err_r, err_nxt;
  logic [bfscd_pkg::MAX_VERTICES-1:0] visited_r, visited_nxt;
  logic [bfscd_pkg::CFG_W-1:0]        vtx_r, vtx_nxt;
  logic [bfscd_pkg::QC_W-1:0]         head_r, head_nxt;
  logic [bfscd_pkg::QC_W-1:0]         tail_r, tail_nxt;
  logic [bfscd_pkg::ECNT_W-1:0]       scan_idx_r, scan_idx_nxt;
  logic                               edge_vld_r, edge_vld_nxt;
  logic                               out_valid_r, out_valid_nxt;
  // payload
  logic [bfscd_pkg::VID_W-1:0]        cur_r;
  logic                               out_found_r;
  logic [bfscd_pkg::ERR_W-1:0]        out_err_r;

  logic                               in_range;
  logic                               store_full;
  logic                               edge_wr;
  logic                               enq_a;
  logic                               enq_b;
  logic                               q_we;
  logic [bfscd_pkg::QA_W-1:0]         q_waddr;
  logic [bfscd_pkg::VID_W-1:0]        q_wdata;
  logic [bfscd_pkg::ERR_W-1:0]        err_code;

  assign in_range   = ({1'b0, in_end_a} < vertex_count) && ({1'b0, in_end_b} < vertex_count);
  assign store_full = (edge_total_r >= bfscd_pkg::ECNT_W'(bfscd_pkg::MAX_EDGES));
  assign edge_wr    = cmd.edge_add && in_range && !store_full;

  // neighbor test; both cannot hold at once since the scanned vertex is marked
  assign enq_b = edge_vld_r && (edge_q_r.a == cur_r) && !visited_r[edge_q_r.b];
  assign enq_a = edge_vld_r && (edge_q_r.b == cur_r) && !visited_r[edge_q_r.a];

  always_comb begin
    q_we    = 1'b0;
    q_waddr = tail_r[bfscd_pkg::QA_W-1:0];
    q_wdata = enq_b ? edge_q_r.b : edge_q_r.a;
    if (cmd.walk_start) begin
      q_we    = 1'b1;
      q_waddr = '0;
      q_wdata = vtx_r[bfscd_pkg::VID_W-1:0];
    end else if (cmd.scan && (enq_a || enq_b)) begin
      q_we = 1'b1;
    end
  end

  always_comb begin
    if (err_r[1]) begin
      err_code = bfscd_pkg::ERR_RANGE;
    end else if (err_r[0]) begin
      err_code = bfscd_pkg::ERR_OVERFLOW;
    end else begin
      err_code = bfscd_pkg::ERR_NONE;
    end
  end

  always_comb begin
    edge_total_nxt = edge_total_r;
    err_nxt        = err_r;
    visited_nxt    = visited_r;
    vtx_nxt        = vtx_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    scan_idx_nxt   = scan_idx_r;
    edge_vld_nxt   = 1'b0;
    out_valid_nxt  = out_valid_r && out_stall;

    if (cmd.edge_add) begin
      if (!in_range) begin
        err_nxt[1] = 1'b1;
      end else if (store_full) begin
        err_nxt[0] = 1'b1;
      end else begin
        edge_total_nxt = edge_total_r + 1'b1;
      end
    end
    if (cmd.walk_init) begin
      vtx_nxt = '0;
    end
    if (cmd.vtx_next) begin
      vtx_nxt = vtx_r + 1'b1;
    end
    if (cmd.walk_start) begin
      head_nxt = '0;
      tail_nxt = bfscd_pkg::QC_W'(1);
    end
    if (cmd.deq) begin
      head_nxt = head_r + 1'b1;
    end
    if (cmd.mark) begin
      visited_nxt[q_rd_r] = 1'b1;
      scan_idx_nxt        = '0;
    end
    if (cmd.scan) begin
      if (scan_idx_r < edge_total_r) begin
        scan_idx_nxt = scan_idx_r + 1'b1;
        edge_vld_nxt = 1'b1;
      end
      if (enq_a || enq_b) begin
        tail_nxt = tail_r + 1'b1;
      end
    end
    if (cmd.post) begin
      out_valid_nxt  = 1'b1;
      edge_total_nxt = '0;
      err_nxt        = '0;
      visited_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_total_r <= '0;
      err_r        <= '0;
      visited_r    <= '0;
      vtx_r        <= '0;
      head_r       <= '0;
      tail_r       <= '0;
      scan_idx_r   <= '0;
      edge_vld_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      edge_total_r <= edge_total_nxt;
      err_r        <= err_nxt;
      visited_r    <= visited_nxt;
      vtx_r        <= vtx_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      scan_idx_r   <= scan_idx_nxt;
      edge_vld_r   <= edge_vld_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mark) begin
      cur_r <= q_rd_r;
    end
    if (cmd.post) begin
      out_found_r <= cmd.found;
      out_err_r   <= err_code;
    end
  end

  // edge store: one write, one registered read
  always_ff @(posedge clk) begin
    if (edge_wr) begin
      edge_mem[edge_total_r[bfscd_pkg::EA_W-1:0]] <= '{a: in_end_a, b: in_end_b};
    end
    edge_q_r <= edge_mem[scan_idx_r[bfscd_pkg::EA_W-1:0]];
  end

  // walk queue: one write, one registered read
  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[q_waddr] <= q_wdata;
    end
    q_rd_r <= q_mem[head_r[bfscd_pkg::QA_W-1:0]];
  end

  assign sts.vtx_end   = (vtx_r >= vertex_count);
  assign sts.vtx_seen  = visited_r[vtx_r[bfscd_pkg::VID_W-1:0]];
  assign sts.q_empty   = (head_r == tail_r);
  assign sts.deq_seen  = visited_r[q_rd_r];
  assign sts.scan_done = (scan_idx_r == edge_total_r) && !edge_vld_r;
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign out_valid       = out_valid_r;
  assign out_cycle_found = out_found_r;
  assign out_load_error  = out_err_r;

endmodule
`default_nettype wire

>>> rtl/bfs_undirected_cycle_detect_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfs_undirected_cycle_detect_core: undirected graph cycle detector (BFS)
// Edge loader plus breadth-first walk that reports whether a cycle exists.
// ----------------------------------------------------------------------------
// Usage: program vertex_count over the APB port, then send one transfer per
// edge (in_mode = 0) and a finish transfer (in_mode = 1). An edge transfer
// writes the 1024-entry edge store, or is dropped and
// flagged if an endpoint is at or above vertex_count (range error, reported
// in preference) or the store is full (overflow). The finish transfer holds
// in_stall high while the walk runs and yields exactly one result transfer:
// out_cycle_found and out_load_error. The walk visits start vertices 0 up to
// vertex_count-1 in order; each unvisited one costs a queue walk in which
// every dequeued vertex passes a dequeue state, a check state and a full
// pass over the stored edges through the single read port of the edge
// store. An early cycle hit ends the walk at once. Parallel edges count
// as a cycle, self-loops do not. After the result is posted the edge store,
// visited marks and error flags are cleared and the next graph can be
// loaded. A result waiting on out_stall does not block edge loading; a new
// finish waits for the result register to drain before posting.
// ----------------------------------------------------------------------------
module bfs_undirected_cycle_detect_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input channel
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              in_mode,
  input  wire logic [bfscd_pkg::VID_W-1:0]       in_end_a,
  input  wire logic [bfscd_pkg::VID_W-1:0]       in_end_b,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   out_cycle_found,
  output logic [bfscd_pkg::ERR_W-1:0]            out_load_error,
  // configuration (APB)
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [bfscd_pkg::ADDR_W-1:0]      paddr,
  input  wire logic [bfscd_pkg::DATA_W-1:0]      pwdata,
  output logic [bfscd_pkg::DATA_W-1:0]           prdata,
  output logic                                   pready
);

  logic [bfscd_pkg::CFG_W-1:0]  vcount_r, vcount_nxt;
  logic [bfscd_pkg::CFG_W-1:0]  wr_count;
  logic [bfscd_pkg::RIDX_W-1:0] reg_idx;
  logic                         cfg_wr;

  bfscd_pkg::bfscd_cmd_t cmd;
  bfscd_pkg::bfscd_sts_t sts;

  // register decode: one 32-bit register per word
  assign reg_idx  = paddr[bfscd_pkg::ADDR_W-1:2];
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign wr_count = pwdata[bfscd_pkg::CFG_W-1:0];

  // vertex_count saturates at the vertex capacity
  always_comb begin
    vcount_nxt = vcount_r;
    if (cfg_wr && (reg_idx == bfscd_pkg::REG_VERTEX_COUNT)) begin
      if (wr_count > bfscd_pkg::CFG_W'(bfscd_pkg::MAX_VERTICES)) begin
        vcount_nxt = bfscd_pkg::CFG_W'(bfscd_pkg::MAX_VERTICES);
      end else begin
        vcount_nxt = wr_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= '0;
    end else begin
      vcount_r <= vcount_nxt;
    end
  end

  always_comb begin
    unique case (reg_idx)
      bfscd_pkg::REG_VERTEX_COUNT: prdata = bfscd_pkg::DATA_W'(vcount_r);
      default:                     prdata = '0;
    endcase
  end

  bfscd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_mode  (in_mode),
    .sts      (sts),
    .cmd      (cmd)
  );

  bfscd_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .vertex_count    (vcount_r),
    .in_end_a        (in_end_a),
    .in_end_b        (in_end_b),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_cycle_found (out_cycle_found),
    .out_load_error  (out_load_error)
  );

endmodule
`default_nettype wire

>>> rtl/bfscd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfscd_checker: port-level assertions for the BFS cycle detector
// Bound to the top level; sees its ports only.
// ----------------------------------------------------------------------------
module bfscd_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_stall,
  input wire logic                              in_mode,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic                              out_cycle_found,
  input wire logic [bfscd_pkg::ERR_W-1:0]       out_load_error
);

  logic in_xfer;
  assign in_xfer = in_valid && !in_stall;

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_cycle_found)
                               && $stable(out_load_error))
    else $error("result changed while stalled");

  // only defined error codes are reported
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_load_error == bfscd_pkg::ERR_NONE)
               || (out_load_error == bfscd_pkg::ERR_OVERFLOW)
               || (out_load_error == bfscd_pkg::ERR_RANGE))
    else $error("undefined load_error code");

  // an edge transfer never blocks the next one
  a_add_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (in_mode == bfscd_pkg::MODE_ADD) |=> !in_stall)
    else $error("stall after edge transfer");

  // a finish transfer starts the walk, which holds the input off
  a_fin_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (in_mode == bfscd_pkg::MODE_FINISH) |=> in_stall)
    else $error("no walk after finish transfer");

  // a new result only appears at the end of a walk
  a_res_walk: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without walk");

endmodule

bind bfs_undirected_cycle_detect_core bfscd_checker u_bfscd_checker (.*);
`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for bfs_undirected_cycle_detect_core
// Streams edge and finish transfers into the core, predicts every verdict
// with a behavioral breadth-first walk kept in a small scoreboard class, and
// compares each result transfer field by field. Random gaps on both
// channels, one long receiver hold-off, several vertex counts.
// ----------------------------------------------------------------------------
module tb;
  import bfscd_pkg::*;

  localparam int CLK_HALF    = 6;
  localparam int RESET_CYC   = 4;
  localparam int DRAIN_CYC   = 16;       // lets trailing edge loads complete
  localparam int CYCLE_LIMIT = 2000000;
  localparam int RANDOM_ITEMS = 150;
  localparam int HOLD_AFTER  = 12;       // results seen before the long hold
  localparam int HOLD_CYC    = 3000;

  // second register slot, decodes to nothing
  localparam logic [RIDX_W-1:0] REG_SPARE = 1'b1;

  typedef struct packed {
    logic             cycle_found;
    logic [ERR_W-1:0] load_error;
  } verdict_t;

  // --------------------------------------------------------------------------
  // Scoreboard: shadow copy of the graph state plus the verdicts still owed.
  // --------------------------------------------------------------------------
  class cycle_scoreboard;
    logic [CFG_W-1:0] vcount;
    bfscd_edge_t      stored[$];
    bit               range_seen;
    bit               overflow_seen;
    verdict_t         verdicts_due[$];
    int               fails;
    int               results_seen;

    function new();
      vcount        = '0;
      range_seen    = 1'b0;
      overflow_seen = 1'b0;
      fails         = 0;
      results_seen  = 0;
    endfunction

    task report_mismatch(string what);
      fails++;
      $display("[%0t] check failed: %s", $time, what);
    endtask

    // register write; count saturates at the vertex capacity
    function void set_reg(logic [RIDX_W-1:0] idx, logic [DATA_W-1:0] data);
      logic [CFG_W-1:0] n;
      if (idx == REG_VERTEX_COUNT) begin
        n = data[CFG_W-1:0];
        vcount = (n > CFG_W'(MAX_VERTICES)) ? CFG_W'(MAX_VERTICES) : n;
      end
    endfunction

    // BFS from every unvisited start below the count; a dequeued vertex that
    // is already marked means a cycle. b end is queued before the a end.
    function bit walk_graph();
      bit visited [MAX_VERTICES];
      int frontier[$];
      int v;
      foreach (visited[i]) visited[i] = 1'b0;
      for (int s = 0; s < int'(vcount); s++) begin
        if (!visited[s]) begin
          frontier.delete();
          frontier = {frontier, s};
          while (frontier.size() != 0) begin
            v = frontier.pop_front();
            if (visited[v]) return 1'b1;
            visited[v] = 1'b1;
            foreach (stored[i]) begin
              if (int'(stored[i].a) == v && !visited[stored[i].b])
                frontier = {frontier, int'(stored[i].b)};
              if (int'(stored[i].b) == v && !visited[stored[i].a])
                frontier = {frontier, int'(stored[i].a)};
            end
          end
        end
      end
      return 1'b0;
    endfunction

    // accepted input transfer
    function void note_input(logic m, logic [VID_W-1:0] ea, logic [VID_W-1:0] eb);
      bfscd_edge_t e;
      verdict_t    vd;
      if (m == MODE_ADD) begin
        // range check wins over the capacity check
        if (CFG_W'(ea) >= vcount || CFG_W'(eb) >= vcount) begin
          range_seen = 1'b1;
        end else if (stored.size() >= MAX_EDGES) begin
          overflow_seen = 1'b1;
        end else begin
          e.a = ea;
          e.b = eb;
          stored = {stored, e};
        end
      end else begin
        vd.cycle_found = walk_graph();
        vd.load_error  = range_seen ? ERR_RANGE : (overflow_seen ? ERR_OVERFLOW : ERR_NONE);
        verdicts_due = {verdicts_due, vd};
        stored.delete();
        range_seen    = 1'b0;
        overflow_seen = 1'b0;
      end
    endfunction

    task check_result(logic cf, logic [ERR_W-1:0] le);
      verdict_t want;
      results_seen++;
      if (verdicts_due.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no finish outstanding",
                                  results_seen));
      end else begin
        want = verdicts_due.pop_front();
        if (cf !== want.cycle_found)
          report_mismatch($sformatf("result %0d cycle_found %b, predicted %b",
                                    results_seen, cf, want.cycle_found));
        if (le !== want.load_error)
          report_mismatch($sformatf("result %0d load_error %0d, predicted %0d",
                                    results_seen, le, want.load_error));
      end
    endtask

    function int pending();
      return verdicts_due.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic             in_valid  = 1'b0;
  logic             in_stall;
  logic             in_mode   = MODE_ADD;
  logic [VID_W-1:0] in_end_a  = '0;
  logic [VID_W-1:0] in_end_b  = '0;

  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             out_cycle_found;
  logic [ERR_W-1:0] out_load_error;

  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [DATA_W-1:0] pwdata  = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  cycle_scoreboard sb;
  int  cycle_count = 0;
  int  items_sent  = 0;
  bit  idle_on     = 1'b1;   // cleared for stretches with no gaps at all

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  bfs_undirected_cycle_detect_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_end_a        (in_end_a),
    .in_end_b        (in_end_b),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_cycle_found (out_cycle_found),
    .out_load_error  (out_load_error),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // --------------------------------------------------------------------------
  // Gap lengths: mostly none or short, now and then a long one
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // --------------------------------------------------------------------------
  // Input side. Every assignment lands right after a rising edge, so the
  // core samples a stable payload; valid stays up between back-to-back
  // transfers (one NBA per step).
  // --------------------------------------------------------------------------
  task automatic send_item(input logic m, input logic [VID_W-1:0] ea,
                           input logic [VID_W-1:0] eb);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode  <= m;
    in_end_a <= ea;
    in_end_b <= eb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // transfer taken at this edge
    sb.note_input(m, ea, eb);
    items_sent++;
  endtask

  task automatic add_edge(input int ea, input int eb);
    send_item(MODE_ADD, VID_W'(ea), VID_W'(eb));
  endtask

  // endpoints are don't-care on a finish, so drive noise there
  task automatic finish_graph();
    send_item(MODE_FINISH, VID_W'($urandom), VID_W'($urandom));
  endtask

  // Drop valid, wait for every verdict, then let any trailing edge load
  // complete before the register may change.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  // APB write (setup + access) followed by a read-back of the same slot
  task automatic reg_write(input logic [RIDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(idx, data);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_VERTEX_COUNT && prdata[CFG_W-1:0] !== sb.vcount)
      sb.report_mismatch($sformatf("vertex_count reads %0d, predicted %0d",
                                   prdata[CFG_W-1:0], sb.vcount));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Random graphs. Forests (acyclic by construction: each new vertex hooks
  // to an earlier one), forests with one extra edge, and plain random edge
  // sets; a few edges get endpoints from the full id range as noise.
  // --------------------------------------------------------------------------
  task automatic send_graph(input int nv);
    int order[$];
    int kind, ne, j, t, ea, eb;
    kind = $urandom_range(0, 2);
    ne   = (nv >= 64) ? $urandom_range(0, 6) : $urandom_range(0, 12);
    for (int k = 0; k < nv; k++) order = {order, k};
    for (int k = nv - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      t = order[k];
      order[k] = order[j];
      order[j] = t;
    end
    for (int k = 0; k < ne; k++) begin
      if (kind != 1 && k + 1 < nv && !(kind == 2 && k == ne - 1)) begin
        ea = order[k + 1];
        eb = order[$urandom_range(0, k)];
      end else if (nv > 0) begin
        ea = $urandom_range(0, nv - 1);
        eb = $urandom_range(0, nv - 1);
      end else begin
        ea = $urandom_range(0, 255);
        eb = $urandom_range(0, 255);
      end
      if ($urandom_range(0, 99) < 8) begin
        ea = $urandom_range(0, 255);
        eb = $urandom_range(0, 255);
      end
      if ($urandom_range(0, 1) == 1) begin
        t  = ea;
        ea = eb;
        eb = t;
      end
      add_edge(ea, eb);
    end
    finish_graph();
  endtask

  // one setting of vertex_count and a batch of graphs under it
  task automatic random_phase();
    int pick, nv, graphs;
    logic [DATA_W-1:0] word;
    pick = $urandom_range(0, 99);
    if (pick < 60)      nv = $urandom_range(2, 12);
    else if (pick < 80) nv = $urandom_range(13, 40);
    else if (pick < 88) nv = MAX_VERTICES;
    else if (pick < 94) nv = $urandom_range(MAX_VERTICES + 1, 511);
    else if (pick < 97) nv = 0;
    else                nv = 1;
    word = nv;
    // junk above the 9-bit field must be dropped
    if ($urandom_range(0, 3) == 0) begin
      word = $urandom;
      word[CFG_W-1:0] = CFG_W'(nv);
    end
    settle();
    idle_on = ($urandom_range(0, 3) != 0);
    reg_write(REG_VERTEX_COUNT, word);
    graphs = $urandom_range(4, 12);
    repeat (graphs) send_graph((nv > MAX_VERTICES) ? MAX_VERTICES : nv);
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall runs, plus one long hold-off so the result
  // register stays full and the core backs up its input.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int  got, hold_left, run_left, r;
    bit  run_stall, held;
    got       = 0;
    hold_left = 0;
    run_left  = 0;
    run_stall = 1'b0;
    held      = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        sb.check_result(out_cycle_found, out_load_error);
        got++;
      end
      if (!held && got == HOLD_AFTER) begin
        held      = 1'b1;
        hold_left = HOLD_CYC;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (run_left == 0) begin
          r = $urandom_range(0, 99);
          if (!idle_on || r < 50) begin
            run_stall = 1'b0;
            run_left  = $urandom_range(1, 8);
          end else if (r < 85) begin
            run_stall = 1'b1;
            run_left  = $urandom_range(1, 3);
          end else if (r < 97) begin
            run_stall = 1'b1;
            run_left  = $urandom_range(4, 15);
          end else begin
            run_stall = 1'b1;
            run_left  = $urandom_range(30, 80);
          end
        end
        run_left--;
        out_stall <= run_stall;
      end
    end
  end

  // watchdog
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int random_start;
    sb = new();
    repeat (RESET_CYC) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero vertices: empty graph, then every edge out of range
    reg_write(REG_VERTEX_COUNT, 0);
    finish_graph();
    add_edge(0, 0);
    finish_graph();

    // count above capacity saturates; parallel edge on the top id
    settle();
    reg_write(REG_VERTEX_COUNT, 300);
    add_edge(255, 0);
    add_edge(0, 255);
    finish_graph();
    // self-loops alone are never a cycle
    add_edge(3, 3);
    add_edge(1, 2);
    add_edge(255, 255);
    finish_graph();

    // triangle, then a path with one out-of-range edge
    settle();
    reg_write(REG_VERTEX_COUNT, 3);
    add_edge(0, 1);
    add_edge(1, 2);
    add_edge(2, 0);
    finish_graph();
    add_edge(0, 1);
    add_edge(1, 2);
    add_edge(3, 0);
    finish_graph();

    // write to an undecoded slot leaves the count alone
    settle();
    reg_write(REG_SPARE, 0);
    add_edge(2, 1);
    finish_graph();

    // upper data bits are dropped: count becomes 5
    settle();
    reg_write(REG_VERTEX_COUNT, 32'hFFFF_FE05);
    add_edge(4, 3);
    add_edge(3, 0);
    finish_graph();

    // count lowered after loading: ring 5-6-7 is only reachable through 0
    settle();
    reg_write(REG_VERTEX_COUNT, 8);
    add_edge(0, 5);
    add_edge(5, 6);
    add_edge(6, 7);
    add_edge(7, 5);
    settle();
    reg_write(REG_VERTEX_COUNT, 2);
    finish_graph();

    // store full of self-loops, two more in-range edges overflow
    settle();
    reg_write(REG_VERTEX_COUNT, 8);
    for (int k = 0; k < MAX_EDGES; k++) begin
      int v;
      v = k % 8;
      add_edge(v, v);
    end
    add_edge(1, 2);
    add_edge(3, 4);
    finish_graph();

    // random graphs under many settings
    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) random_phase();

    settle();
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
